// ----- hw/rtl/ppte_pkg.sv -----
// shared types, constants and helpers for the piecewise polynomial evaluator
// no dependencies; imported by piecewise_poly_trajectory_eval and the testbench
package ppte_pkg;

	localparam int MAX_SEGMENTS_DEF    = 16;
	localparam int COEFFS_PER_AXIS_DEF = 6;
	localparam int AXES                = 3;
	localparam int NUM_VALUES          = 9;
	localparam int COEFF_W             = 32;
	localparam int TIME_W              = 24;
	localparam int VAL_W               = 48;
	localparam int MUL_A_W             = 33;
	localparam int MUL_B_W             = 25;
	localparam int MUL_P_W             = MUL_A_W + MUL_B_W;
	localparam int PROD_W              = MUL_P_W + 16;
	localparam int SUM_W               = MUL_P_W + 2;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	localparam logic [1:0] ORD_ACC = 2'd2;
	localparam logic [1:0] AXIS_Z  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_MHI,
		ST_WC,
		ST_SUM,
		ST_DONE
	} state_t;

	// derivative weight of the coefficient of t^j: 1, j or j*(j-1)
	function automatic logic [6:0] coeff_weight(input int ord, input int j);
		int w;
		case (ord)
			0:       w = 1;
			1:       w = j;
			default: w = j * (j - 1);
		endcase
		return 7'(w);
	endfunction

endpackage

// ----- hw/rtl/ppte_ram.sv -----
// generic single write port, single read port ram with registered read
// depends on ppte_pkg only by convention (no package items used)
module ppte_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 288
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/piecewise_poly_trajectory_eval.sv -----
// top level of the piecewise polynomial trajectory evaluator
// depends on ppte_pkg and ppte_ram
//
// A load request (cmd 0) writes one Q16.16 coefficient into the coefficient
// ram in the cycle it is accepted and gives no result; a load whose segment,
// axis or power is out of range is dropped. An evaluate request (cmd 1)
// returns position, velocity and acceleration of x, y and z at the given
// Q8.16 local time as saturated Q32.16 values, plus a flag set if any Horner
// step clipped. All multiplication runs on one 33x25 signed multiplier: each
// Horner step runs in turn through ram read with low half of acc*t, high half
// of acc*t, weight times coefficient, and add and saturate, and an evaluate
// takes 9*(COEFFS_PER_AXIS-1) steps. An evaluate of a segment at or beyond
// MAX_SEGMENTS returns all zeros. A finished result sits in an output
// register, so the next request is taken while it waits. Coefficients must
// be loaded before they are evaluated; the ram has no reset.
module piecewise_poly_trajectory_eval
	import ppte_pkg::*;
#(
	parameter int MAX_SEGMENTS    = MAX_SEGMENTS_DEF,
	parameter int COEFFS_PER_AXIS = COEFFS_PER_AXIS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// request channel
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     cmd,
	input  logic [3:0]               segment,
	input  logic [1:0]               axis,
	input  logic [2:0]               coeff_index,
	input  logic signed [31:0]       coeff_value,
	input  logic [23:0]              local_time,
	// result channel
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [VAL_W-1:0]  pos_x,
	output logic signed [VAL_W-1:0]  pos_y,
	output logic signed [VAL_W-1:0]  pos_z,
	output logic signed [VAL_W-1:0]  vel_x,
	output logic signed [VAL_W-1:0]  vel_y,
	output logic signed [VAL_W-1:0]  vel_z,
	output logic signed [VAL_W-1:0]  acc_x,
	output logic signed [VAL_W-1:0]  acc_y,
	output logic signed [VAL_W-1:0]  acc_z,
	output logic                     saturated
);

	localparam int DEPTH = MAX_SEGMENTS * AXES * COEFFS_PER_AXIS;
	localparam int AW    = $clog2(DEPTH);
	localparam int JW    = $clog2(COEFFS_PER_AXIS);
	localparam int RIW   = $clog2(NUM_VALUES);
	localparam logic [JW-1:0] J_TOP = JW'(COEFFS_PER_AXIS - 1);

	// sequencer state
	state_t state_q, state_n;

	// working registers
	logic [3:0]              seg_q;
	logic [TIME_W-1:0]       t_q;
	logic                    oor_q;     // evaluate of a segment beyond the table
	logic [1:0]              axis_q;
	logic [1:0]              ord_q;     // 0 position, 1 velocity, 2 acceleration
	logic [JW-1:0]           j_q;       // current power in the Horner chain
	logic signed [VAL_W-1:0] acc_q;
	logic                    sat_q;
	logic [MUL_P_W-1:0]      plo_q;     // acc low half times t
	logic [MUL_P_W-1:0]      phi_q;     // acc high half times t
	logic [MUL_P_W-1:0]      wc_q;      // weight times coefficient
	logic [PROD_W-1:0]       prod_q;    // full acc*t
	logic signed [VAL_W-1:0] res_q [NUM_VALUES];
	logic [RIW-1:0]          res_idx;   // slot of the value being finished

	// output register
	logic                    out_valid_q;
	logic signed [VAL_W-1:0] out_q [NUM_VALUES];
	logic                    out_sat_q;

	// request decode
	logic in_acc;
	logic load_ok;
	logic seg_in_range;

	assign in_ready     = (state_q == ST_IDLE);
	assign in_acc       = in_valid && in_ready;
	assign seg_in_range = (32'(segment) < MAX_SEGMENTS);
	assign load_ok      = seg_in_range && (32'(axis) < AXES)
		&& (32'(coeff_index) < COEFFS_PER_AXIS);

	// coefficient ram
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [AW-1:0]     ram_raddr;
	logic [COEFF_W-1:0] ram_rdata;

	assign ram_we    = in_acc && (cmd == CMD_LOAD) && load_ok;
	assign ram_waddr = AW'((int'(segment) * AXES + int'(axis)) * COEFFS_PER_AXIS
		+ int'(coeff_index));
	assign ram_raddr = AW'((int'(seg_q) * AXES + int'(axis_q)) * COEFFS_PER_AXIS
		+ int'(j_q));

	ppte_ram #(
		.WIDTH (COEFF_W),
		.DEPTH (DEPTH)
	) u_coeff_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (coeff_value),
		.re    (state_q == ST_RD),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// shared multiplier, operands picked by the sequencer state
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	logic [6:0]                w_cur;

	assign w_cur = coeff_weight(int'(ord_q), int'(j_q));

	always_comb begin
		case (state_q)
			ST_RD: begin
				// low 24 bits of acc, unsigned
				mul_a = $signed({9'b0, acc_q[23:0]});
				mul_b = $signed({1'b0, t_q});
			end
			ST_MHI: begin
				// high 24 bits of acc, signed
				mul_a = $signed({{9{acc_q[VAL_W-1]}}, acc_q[VAL_W-1:24]});
				mul_b = $signed({1'b0, t_q});
			end
			ST_WC: begin
				mul_a = $signed({ram_rdata[COEFF_W-1], ram_rdata});
				mul_b = $signed({18'b0, w_cur});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// full product acc*t = phi*2^24 + plo
	logic signed [PROD_W-1:0] prod_n;
	assign prod_n = ($signed({{16{phi_q[MUL_P_W-1]}}, phi_q}) <<< 24)
		+ $signed({{16{plo_q[MUL_P_W-1]}}, plo_q});

	// floor(acc*t / 2^16) + w*c, with the scaled term zero on the first step, then clip to 48 bits
	logic                      first_step;
	logic signed [SUM_W-1:0]   sum_n;
	logic signed [SUM_W-1:0]   scaled;
	logic signed [VAL_W-1:0]   acc_n;
	logic                      clip_n;

	assign first_step = (j_q == J_TOP);
	assign scaled     = first_step ? '0
		: $signed({{2{prod_q[PROD_W-1]}}, prod_q[PROD_W-1:16]});
	assign sum_n      = scaled + $signed({{2{wc_q[MUL_P_W-1]}}, wc_q});
	assign clip_n     = (sum_n[SUM_W-1:VAL_W-1] != '0) && (sum_n[SUM_W-1:VAL_W-1] != '1);
	always_comb begin
		if (!clip_n) begin
			acc_n = sum_n[VAL_W-1:0];
		end else if (sum_n[SUM_W-1]) begin
			acc_n = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			acc_n = {1'b0, {(VAL_W-1){1'b1}}};
		end
	end

	logic last_of_chain;
	logic out_free;
	assign last_of_chain = (32'(j_q) == 32'(ord_q));
	assign out_free      = !out_valid_q || out_ready;
	assign res_idx       = RIW'(int'(ord_q) * AXES + int'(axis_q));

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (cmd == CMD_EVAL)) begin
					state_n = seg_in_range ? ST_RD : ST_DONE;
				end
			end
			ST_RD:  state_n = ST_MHI;
			ST_MHI: state_n = ST_WC;
			ST_WC:  state_n = ST_SUM;
			ST_SUM: begin
				if (last_of_chain && (ord_q == ORD_ACC) && (axis_q == AXIS_Z)) begin
					state_n = ST_DONE;
				end else begin
					state_n = ST_RD;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (cmd == CMD_EVAL)) begin
					seg_q  <= segment;
					t_q    <= local_time;
					oor_q  <= !seg_in_range;
					axis_q <= '0;
					ord_q  <= '0;
					j_q    <= J_TOP;
					sat_q  <= 1'b0;
				end
			end
			ST_RD:  plo_q <= mul_p;
			ST_MHI: phi_q <= mul_p;
			ST_WC: begin
				wc_q   <= mul_p;
				prod_q <= prod_n;
			end
			ST_SUM: begin
				acc_q <= acc_n;
				sat_q <= sat_q | clip_n;
				if (last_of_chain) begin
					// value done: store, move to next derivative or axis
					res_q[res_idx] <= acc_n;
					j_q <= J_TOP;
					if (ord_q == ORD_ACC) begin
						ord_q  <= '0;
						axis_q <= axis_q + 2'd1;
					end else begin
						ord_q <= ord_q + 2'd1;
					end
				end else begin
					j_q <= j_q - JW'(1);
				end
			end
			ST_DONE: begin
				if (out_free) begin
					for (int k = 0; k < NUM_VALUES; k++) begin
						out_q[k] <= oor_q ? '0 : res_q[k];
					end
					out_sat_q <= oor_q ? 1'b0 : sat_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign pos_x     = out_q[0];
	assign pos_y     = out_q[1];
	assign pos_z     = out_q[2];
	assign vel_x     = out_q[3];
	assign vel_y     = out_q[4];
	assign vel_z     = out_q[5];
	assign acc_x     = out_q[6];
	assign acc_y     = out_q[7];
	assign acc_z     = out_q[8];
	assign saturated = out_sat_q;

	// a load never leaves the sequencer busy
	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (cmd == CMD_LOAD)) |=> (state_q == ST_IDLE))
		else $error("load request left the sequencer busy");

	// an evaluate always blocks new requests in the next cycle
	a_eval_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (cmd == CMD_EVAL)) |=> !in_ready)
		else $error("evaluate request did not make the block busy");

	// the ram is never written while a chain is being evaluated
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE))
		else $error("coefficient write during evaluation");

	// the Horner chain never runs below the lowest weighted power
	a_chain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM) |-> (32'(j_q) >= 32'(ord_q)))
		else $error("horner step below lowest power");

	// a result appears only when the sequencer hands it over
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result raised outside the done state");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for piecewise_poly_trajectory_eval: coefficient loads and evaluates
// against a cycle-free kinematics predictor kept in a small scoreboard class
// depends on ppte_pkg and the rtl of the block under test
module tb;
	import ppte_pkg::*;

	localparam int NSEG = MAX_SEGMENTS_DEF;
	localparam int NC   = COEFFS_PER_AXIS_DEF;

	// corner coefficients of the z axis in the directed part: 0, 1.0, tiny negative,
	// both extremes and -1.0
	localparam logic [31:0] Z_CORNER [NC] = '{32'h0000_0000, 32'h0001_0000, 32'hFFFF_FFFF,
		32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000};

	// one evaluate result: pos x y z, vel x y z, acc x y z from index 0 up, plus the flag
	typedef struct packed {
		logic [NUM_VALUES-1:0][VAL_W-1:0] val;
		logic                             sat;
	} kin_sample_t;

	// mirror of the coefficient ram plus the queue of kinematics still owed by the block
	class KinematicsTracker;
		logic signed [COEFF_W-1:0] coeff_mem [NSEG][AXES][NC];
		kin_sample_t               owed_samples [$];
		int                        errors;
		int                        checked;

		function longint deriv_weight(int ord, int j);
			if (ord == 0)
				return 1;
			if (ord == 1)
				return longint'(j);
			return longint'(j * (j - 1));
		endfunction

		// clip to the signed 48-bit range and remember that it happened
		function longint clip48(longint v, inout bit sat);
			longint hi_lim, lo_lim;
			hi_lim = (longint'(1) <<< 47) - 1;
			lo_lim = -(longint'(1) <<< 47);
			if (v > hi_lim) begin
				sat = 1'b1;
				return hi_lim;
			end
			if (v < lo_lim) begin
				sat = 1'b1;
				return lo_lim;
			end
			return v;
		endfunction

		// horner from the top power down, flooring acc*t/2^16 and clipping every step
		function kin_sample_t predict_kinematics(logic [3:0] seg, logic [TIME_W-1:0] t);
			kin_sample_t r;
			bit          sat;
			longint      t_int, t_frac, acc, cj;
			r      = '0;
			sat    = 1'b0;
			t_int  = longint'(t[23:16]);
			t_frac = longint'(t[15:0]);
			for (int a = 0; a < AXES; a++) begin
				for (int ord = 0; ord < 3; ord++) begin
					cj  = longint'(coeff_mem[seg][a][NC-1]);
					acc = clip48(deriv_weight(ord, NC - 1) * cj, sat);
					for (int j = NC - 2; j >= ord; j--) begin
						cj  = longint'(coeff_mem[seg][a][j]);
						acc = clip48(acc * t_int + ((acc * t_frac) >>> 16)
							+ deriv_weight(ord, j) * cj, sat);
					end
					r.val[ord * AXES + a] = acc[VAL_W-1:0];
				end
			end
			r.sat = sat;
			return r;
		endfunction

		// called once per accepted request
		function void accept_request(logic c, logic [3:0] seg, logic [1:0] ax,
				logic [2:0] idx, logic signed [31:0] v, logic [TIME_W-1:0] t);
			if (c == CMD_EVAL)
				owed_samples.push_back(predict_kinematics(seg, t));
			else if (int'(ax) < AXES && int'(idx) < NC)
				coeff_mem[seg][ax][idx] = v;
		endfunction

		function string field_name(int k);
			string kind, ax;
			case (k / AXES)
				0:       kind = "pos";
				1:       kind = "vel";
				default: kind = "acc";
			endcase
			case (k % AXES)
				0:       ax = "x";
				1:       ax = "y";
				default: ax = "z";
			endcase
			return {kind, "_", ax};
		endfunction

		// one line per mismatch; the log stops growing after a hundred
		task report(string what);
			errors++;
			if (errors <= 100)
				$display("[%0t] mismatch: %s", $time, what);
		endtask

		task match_result(kin_sample_t got);
			kin_sample_t want;
			if (owed_samples.size() == 0) begin
				report("result with no evaluate outstanding");
				return;
			end
			want = owed_samples.pop_front();
			for (int k = 0; k < NUM_VALUES; k++)
				if (got.val[k] !== want.val[k])
					report($sformatf("result %0d %s got %0d want %0d", checked,
						field_name(k), $signed(got.val[k]), $signed(want.val[k])));
			if (got.sat !== want.sat)
				report($sformatf("result %0d saturated got %b want %b", checked,
					got.sat, want.sat));
			checked++;
		endtask

		function int pending();
			return owed_samples.size();
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;

	logic                    in_valid    = 1'b0;
	logic                    in_ready;
	logic                    cmd         = CMD_LOAD;
	logic [3:0]              segment     = '0;
	logic [1:0]              axis        = '0;
	logic [2:0]              coeff_index = '0;
	logic signed [31:0]      coeff_value = '0;
	logic [23:0]             local_time  = '0;

	logic                    out_valid;
	logic                    out_ready   = 1'b0;
	logic signed [VAL_W-1:0] pos_x, pos_y, pos_z;
	logic signed [VAL_W-1:0] vel_x, vel_y, vel_z;
	logic signed [VAL_W-1:0] acc_x, acc_y, acc_z;
	logic                    saturated;

	KinematicsTracker kin = new;

	// which coefficients have been written; only segments with all 18 written are evaluated
	bit loaded [NSEG][AXES][NC];
	bit in_calm;
	bit out_calm;
	int n_items;
	int n_evals;

	piecewise_poly_trajectory_eval dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#10ms;
		$display("timeout: block stopped taking requests or returning results");
		$display("CHECK FAILED");
		$finish;
	end

	function automatic bit seg_loaded(int s);
		for (int a = 0; a < AXES; a++)
			for (int j = 0; j < NC; j++)
				if (!loaded[s][a][j])
					return 1'b0;
		return 1'b1;
	endfunction

	// mostly values that keep trajectories in range, with regular extremes
	function automatic logic signed [31:0] pick_coeff();
		case ($urandom_range(0, 5))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return '0;
			3:       return 32'($urandom_range(0, 'h7FFFF)) - 32'h4_0000;
			4:       return 32'($urandom_range(0, 'h1FF_FFFF)) - 32'h100_0000;
			default: return 32'($urandom);
		endcase
	endfunction

	// local time: realistic spans under two seconds, the ends, or anything
	function automatic logic [23:0] pick_time();
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return 24'hFF_FFFF;
			2:       return 24'($urandom_range(0, 'hFFFF));
			3:       return 24'($urandom_range(0, 'h1_FFFF));
			default: return 24'($urandom);
		endcase
	endfunction

	// present one request after a random gap and hold it until taken; valid is only
	// dropped at the start of a gap so it never toggles twice in one step
	task automatic send_request(logic c, logic [3:0] seg, logic [1:0] ax, logic [2:0] idx,
			logic signed [31:0] v, logic [23:0] t);
		int gap;
		gap = in_calm ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		cmd         <= c;
		segment     <= seg;
		axis        <= ax;
		coeff_index <= idx;
		coeff_value <= v;
		local_time  <= t;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
		kin.accept_request(c, seg, ax, idx, v, t);
		if (c == CMD_EVAL) begin
			n_evals++;
			n_items++;
		end else if (int'(ax) < AXES && int'(idx) < NC) begin
			loaded[seg][ax][idx] = 1'b1;
			n_items++;
		end
	endtask

	// result side: random back-pressure with calm stretches, check on every accept
	initial begin : result_side
		int          stall;
		int          n_seen;
		kin_sample_t got;
		n_seen = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (n_seen % 20 == 0)
				out_calm = ($urandom_range(0, 3) == 0);
			stall = out_calm ? 0 : $urandom_range(0, 5);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!(out_valid && out_ready));
			got.val = {acc_z, acc_y, acc_x, vel_z, vel_y, vel_x, pos_z, pos_y, pos_x};
			got.sat = saturated;
			kin.match_result(got);
			n_seen++;
		end
	end

	initial begin : stimulus
		int  kind, s, found;
		bit  full;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: segment 0 with x at the positive extreme, y at the negative extreme
		// and z a mix of corners, load time ignored so driven with junk
		in_calm = 1'b0;
		for (int a = 0; a < AXES; a++)
			for (int j = 0; j < NC; j++)
				send_request(CMD_LOAD, 4'd0, 2'(a), 3'(j),
					(a == 0) ? 32'h7FFF_FFFF : (a == 1) ? 32'h8000_0000 : Z_CORNER[j],
					24'($urandom));
		// time zero, full scale (saturates hard) and exactly 1.0
		send_request(CMD_EVAL, 4'd0, 2'd3, 3'd7, 32'h8000_0000, 24'h00_0000);
		send_request(CMD_EVAL, 4'd0, 2'd0, 3'd0, 32'h7FFF_FFFF, 24'hFF_FFFF);
		send_request(CMD_EVAL, 4'd0, 2'd1, 3'd5, 32'h0000_0000, 24'h01_0000);
		// out-of-range loads must leave segment 0 untouched
		send_request(CMD_LOAD, 4'd0, 2'd3, 3'd0, 32'h1234_5678, 24'h00_0000);
		send_request(CMD_LOAD, 4'd0, 2'd0, 3'd6, 32'h0000_0000, 24'hFF_FFFF);
		send_request(CMD_LOAD, 4'd0, 2'd2, 3'd7, 32'hFFFF_FFFF, 24'h00_0000);
		send_request(CMD_EVAL, 4'd0, 2'd2, 3'd2, 32'h5555_5555, 24'hFF_FFFF);

		// random bursts: mostly load-then-evaluate sequences, some evaluates of
		// segments already built, some noise loads including out-of-range ones
		while (n_items < 800 || n_evals < 60) begin
			in_calm = ($urandom_range(0, 4) == 0);
			kind    = $urandom_range(0, 9);
			if (kind < 6) begin
				s    = $urandom_range(0, NSEG - 1);
				full = seg_loaded(s);
				// a built segment gets a partial rewrite, a new one a full load
				for (int a = 0; a < AXES; a++)
					for (int j = 0; j < NC; j++)
						if (!full || $urandom_range(0, 1) == 0)
							send_request(CMD_LOAD, 4'(s), 2'(a), 3'(j), pick_coeff(),
								24'($urandom));
				repeat ($urandom_range(1, 3))
					send_request(CMD_EVAL, 4'(s), 2'($urandom), 3'($urandom),
						32'($urandom), pick_time());
			end else if (kind < 8) begin
				repeat ($urandom_range(1, 4))
					send_request(CMD_LOAD, 4'($urandom), 2'($urandom), 3'($urandom),
						32'($urandom), 24'($urandom));
			end else begin
				found = -1;
				s     = $urandom_range(0, NSEG - 1);
				for (int k = 0; k < NSEG; k++)
					if (found < 0 && seg_loaded((s + k) % NSEG))
						found = (s + k) % NSEG;
				if (found >= 0)
					repeat ($urandom_range(1, 3))
						send_request(CMD_EVAL, 4'(found), 2'($urandom), 3'($urandom),
							32'($urandom), pick_time());
			end
		end
		in_valid <= 1'b0;

		// drain, then give any stray result a full evaluate time to show up
		while (kin.pending() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (kin.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/ppte_pkg.sv
hw/rtl/ppte_ram.sv
hw/rtl/piecewise_poly_trajectory_eval.sv
tb/tb.sv
